// File: hw/rtl/swd_pkg.sv
package swd_pkg;

   // register indexes on the csr port
   localparam logic REG_FIRST_INDEX = 1'b0;
   localparam logic REG_LED_COUNT   = 1'b1;

   // item operations
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam int CSR_DATA_W = 10;
   localparam int WL_W       = 10;

   // phase step: 534/256 of a 1/65536 turn per tick and speed unit
   localparam logic [9:0] SPEED_SCALE = 10'd534;

   // divider for 65536 / wavelength, one quotient bit per step
   localparam int DIV_STEPS = 17;

   // lightness scaling: l = lightness * (255 + s) / 510
   localparam logic [8:0]  MID_LEVEL   = 9'd255;
   localparam logic [15:0] RECIP_255   = 16'd32897;
   localparam int          RECIP_SHIFT = 23;

   // quarter-wave table build in 2^30 fixed point
   localparam int          FX_ONE_SHIFT = 30;
   localparam logic [63:0] HALF_PI_FX   = 64'd1686629713;

   typedef struct packed {
      logic       op;
      logic [9:0] wavelength;
      logic [9:0] speed;
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] lightness;
   } req_type;

   typedef struct packed {
      logic [10:0] pixel_index;
      logic [7:0]  out_hue;
      logic [7:0]  out_saturation;
      logic [7:0]  out_lightness;
      logic        last;
   } rsp_type;

   // what travels with a pixel down the shading pipeline
   typedef struct packed {
      logic [10:0] pixel_index;
      logic [7:0]  hue;
      logic [7:0]  saturation;
      logic [7:0]  lightness;
      logic        last;
   } pix_meta_type;

   typedef struct packed {
      logic [15:0]  angle;
      pix_meta_type meta;
   } pix_issue_type;

   // one quarter-wave table entry, evaluated at elaboration only
   function automatic logic [7:0] sine_mag(input logic [12:0] k, input logic [3:0] tab_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x = (HALF_PI_FX * {51'd0, k}) >> tab_bits;
      x2 = (x * x) >> FX_ONE_SHIFT;
      term = x;
      sum = x;
      for (int j = 1; j <= 8; j++) begin
         term = ((term * x2) >> FX_ONE_SHIFT) / 64'((2 * j) * (2 * j + 1));
         if ((j % 2) == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      sum = (64'd255 * sum + (64'd1 << (FX_ONE_SHIFT - 1))) >> FX_ONE_SHIFT;
      return (sum > 64'd255) ? 8'd255 : sum[7:0];
   endfunction

endpackage

// File: hw/rtl/swd_div.sv
module swd_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [swd_pkg::WL_W-1:0]   divisor,
   output logic                       busy,
   output logic [15:0]                quotient,
   output logic [swd_pkg::WL_W-1:0]   remainder
);

   localparam int STEP_W = $clog2(swd_pkg::DIV_STEPS);

   logic                      busy_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [swd_pkg::WL_W-1:0]  dvs_ff;
   logic [swd_pkg::WL_W-1:0]  rem_ff;
   logic [swd_pkg::WL_W-1:0]  rem_in;
   logic [15:0]               quo_ff;
   logic [swd_pkg::WL_W:0]    shifted;
   logic                      qbit;

   // restoring step; the dividend 2^16 has its only set bit in the first step
   always_comb begin
      shifted = {rem_ff, (step_ff == '0)};
      qbit    = (shifted >= {1'b0, dvs_ff});
      rem_in  = qbit ? swd_pkg::WL_W'(shifted - {1'b0, dvs_ff})
                     : shifted[swd_pkg::WL_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(swd_pkg::DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         dvs_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[14:0], qbit};
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: hw/rtl/swd_sine_rom.sv
module swd_sine_rom #(
   parameter int TAB_BITS = 8
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [TAB_BITS:0] addr,
   output logic [7:0]        rd_data
);

   localparam int TAB_N = 1 << TAB_BITS;

   logic [7:0] rom [0:TAB_N];
   logic [7:0] rd_ff;

   // quarter-wave contents, fixed at elaboration
   for (genvar g = 0; g <= TAB_N; g++) begin : g_rom
      assign rom[g] = swd_pkg::sine_mag(13'(g), 4'(TAB_BITS));
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= rom[addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

// File: hw/rtl/swd_shade.sv
module swd_shade #(
   parameter int TAB_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   issue_valid,
   input  swd_pkg::pix_issue_type issue,
   output logic                   issue_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output swd_pkg::rsp_type       rsp_data
);

   localparam int TAB_N = 1 << TAB_BITS;

   logic                      en;
   logic [TAB_BITS-1:0]       k;
   logic [TAB_BITS:0]         addr;
   logic [7:0]                mag;

   logic                      v1_ff;
   logic                      neg1_ff;
   swd_pkg::pix_meta_type     meta1_ff;
   logic                      v2_ff;
   logic [16:0]               prod2_ff;
   swd_pkg::pix_meta_type     meta2_ff;
   logic                      v3_ff;
   swd_pkg::rsp_type          rsp_ff;

   logic [8:0]                level;
   logic [16:0]               prod_in;
   logic [31:0]               scaled;

   // whole pipeline moves unless the output transfer is held
   assign en          = !v3_ff || !rsp_stall;
   assign issue_ready = en;

   // quadrant fold onto the quarter-wave table
   always_comb begin
      k    = issue.angle[13 -: TAB_BITS];
      addr = issue.angle[14] ? ((TAB_BITS+1)'(TAB_N) - {1'b0, k}) : {1'b0, k};
   end

   swd_sine_rom #(.TAB_BITS(TAB_BITS)) u_rom (
      .clock   (clock),
      .rd_en   (en),
      .addr    (addr),
      .rd_data (mag)
   );

   // stage 2 arithmetic: lightness * (255 + s)
   always_comb begin
      level   = neg1_ff ? (swd_pkg::MID_LEVEL - {1'b0, mag})
                        : (swd_pkg::MID_LEVEL + {1'b0, mag});
      prod_in = {9'd0, meta1_ff.lightness} * {8'd0, level};
   end

   // divide by 510: halve, then reciprocal of 255
   assign scaled = {16'd0, prod2_ff[16:1]} * {16'd0, swd_pkg::RECIP_255};

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= issue_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff  <= issue.angle[15];
         meta1_ff <= issue.meta;
         prod2_ff <= prod_in;
         meta2_ff <= meta1_ff;
         rsp_ff.pixel_index    <= meta2_ff.pixel_index;
         rsp_ff.out_hue        <= meta2_ff.hue;
         rsp_ff.out_saturation <= meta2_ff.saturation;
         rsp_ff.out_lightness  <= scaled[swd_pkg::RECIP_SHIFT +: 8];
         rsp_ff.last           <= meta2_ff.last;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/sine_wave_led_dimmer_top.sv
// sequence: a restart clears the counter without stalling the input; a tick gives its first pixel
//   after the counter read, the 17-step divider for 65536/wavelength and the 3 shading stages
// pixels: one per cycle after that unless the output is stalled; the next item is taken only
//   once the last pixel of the tick has been issued to the shading pipeline
// reset: synchronous; registers go to first_index 0, led_count 64, and the counter
//   memory reads as zero until its first write
module sine_wave_led_dimmer_top #(
   parameter int MAX_LEDS        = 64,
   parameter int SINE_TABLE_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  swd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output swd_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [swd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(MAX_LEDS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_RUN  = 2'd3;

   logic [1:0]                state_ff;
   logic [1:0]                state_in;

   logic [9:0]                first_index_ff;
   logic [6:0]                led_count_ff;

   logic                      req_xfer;
   logic                      tick_xfer;
   logic                      restart_xfer;
   logic [CNT_W-1:0]          count_sat;
   logic [swd_pkg::WL_W-1:0]  wl_eff;

   // item registers
   logic [CNT_W-1:0]          count_ff;
   logic [swd_pkg::WL_W-1:0]  wl_ff;
   logic [19:0]               spk_ff;
   logic [7:0]                hue_ff;
   logic [7:0]                sat_ff;
   logic [7:0]                lig_ff;
   logic [15:0]               phase_ff;

   // counter memory
   logic [31:0]               cnt_mem [0:0];
   logic [31:0]               cnt_rd_ff;
   logic                      cnt_written_ff;
   logic                      cnt_we;
   logic [31:0]               cnt_wdata;
   logic [31:0]               tick_cur;
   logic [43:0]               phase_prod;

   // divider
   logic                      div_start;
   logic                      div_busy;
   logic [15:0]               div_quo;
   logic [swd_pkg::WL_W-1:0]  div_rem;

   // angle walk
   logic [15:0]               q0_ff;
   logic [swd_pkg::WL_W-1:0]  r0_ff;
   logic [15:0]               q_acc_ff;
   logic [swd_pkg::WL_W-1:0]  r_acc_ff;
   logic [CNT_W-1:0]          i_ff;
   logic [swd_pkg::WL_W:0]    r_sum;
   logic                      r_wrap;
   logic [15:0]               q_acc_in;
   logic [swd_pkg::WL_W-1:0]  r_acc_in;

   logic                      issue_valid;
   logic                      issue_ready;
   logic                      issue_last;
   swd_pkg::pix_issue_type    issue;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_index_ff <= '0;
         led_count_ff   <= 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            swd_pkg::REG_FIRST_INDEX: first_index_ff <= csr_wdata;
            swd_pkg::REG_LED_COUNT:   led_count_ff   <= csr_wdata[6:0];
         endcase
      end
   end

   // input transfer decode
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_xfer     = req_valid && !req_stall;
   assign tick_xfer    = req_xfer && (req_data.op == swd_pkg::OP_TICK);
   assign restart_xfer = req_xfer && (req_data.op == swd_pkg::OP_RESTART);

   always_comb begin
      count_sat = (led_count_ff > 7'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : CNT_W'(led_count_ff);
      wl_eff    = (req_data.wavelength == '0) ? swd_pkg::WL_W'(count_sat)
                                              : req_data.wavelength;
   end

   // latch the item
   always_ff @(posedge clock) begin
      if (tick_xfer) begin
         count_ff <= count_sat;
         wl_ff    <= wl_eff;
         spk_ff   <= 20'({10'd0, req_data.speed} * {10'd0, swd_pkg::SPEED_SCALE});
         hue_ff   <= req_data.hue;
         sat_ff   <= req_data.saturation;
         lig_ff   <= req_data.lightness;
      end
   end

   // tick counter: read on the tick transfer, written back in the ST_READ state after it;
   // one item at a time, so a read never overlaps a pending write
   assign tick_cur  = cnt_written_ff ? cnt_rd_ff : 32'd0;
   assign cnt_we    = restart_xfer || (state_ff == ST_READ);
   assign cnt_wdata = (state_ff == ST_READ) ? tick_cur + 32'd1 : 32'd0;

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[0] <= cnt_wdata;
      end
      if (tick_xfer) begin
         cnt_rd_ff <= cnt_mem[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_written_ff <= 1'b0;
      end else if (cnt_we) begin
         cnt_written_ff <= 1'b1;
      end
   end

   // phase offset: only bits 23..8 of counter * speed * 534 matter
   assign phase_prod = {20'd0, tick_cur[23:0]} * {24'd0, spk_ff};

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         phase_ff <= phase_prod[23:8];
      end
   end

   // 65536 / wavelength for the per-pixel angle step
   assign div_start = tick_xfer && (count_sat != '0);

   swd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .divisor   (wl_eff),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // next angle: quotient and remainder of (i+1)*65536/wl by one add and wrap
   always_comb begin
      r_sum    = {1'b0, r_acc_ff} + {1'b0, r0_ff};
      r_wrap   = (r_sum >= {1'b0, wl_ff});
      r_acc_in = r_wrap ? swd_pkg::WL_W'(r_sum - {1'b0, wl_ff}) : r_sum[swd_pkg::WL_W-1:0];
      q_acc_in = q_acc_ff + q0_ff + {15'd0, r_wrap};
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIV) && !div_busy) begin
         q0_ff    <= div_quo;
         r0_ff    <= div_rem;
         q_acc_ff <= '0;
         r_acc_ff <= '0;
         i_ff     <= '0;
      end else if ((state_ff == ST_RUN) && issue_ready) begin
         q_acc_ff <= q_acc_in;
         r_acc_ff <= r_acc_in;
         i_ff     <= i_ff + 1'b1;
      end
   end

   // pixel issue
   assign issue_valid = (state_ff == ST_RUN);
   assign issue_last  = (i_ff == count_ff - 1'b1);

   always_comb begin
      issue.angle            = q_acc_ff + phase_ff;
      issue.meta.pixel_index = {1'b0, first_index_ff} + 11'(i_ff);
      issue.meta.hue         = hue_ff;
      issue.meta.saturation  = sat_ff;
      issue.meta.lightness   = lig_ff;
      issue.meta.last        = issue_last;
   end

   swd_shade #(.TAB_BITS(SINE_TABLE_BITS)) u_shade (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue       (issue),
      .issue_ready (issue_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_xfer) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (count_ff == '0) ? ST_IDLE : ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue_ready && issue_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/swd_checker.sv
module swd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input swd_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input swd_pkg::rsp_type                rsp_data
);

   // a held result transfer keeps its pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held pixel changed");

   // a tick keeps the input side busy for at least the counter update
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.op == swd_pkg::OP_TICK) |=> req_stall)
      else $error("input taken during a tick");

   // a restart completes in its own cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.op == swd_pkg::OP_RESTART) |=> !req_stall)
      else $error("restart left the input stalled");

   // reset empties the output
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel shown after reset");

endmodule

bind sine_wave_led_dimmer_top swd_checker u_swd_checker (.*);

// File: test/sine_wave_led_dimmer_top_tb.sv
`timescale 1ns / 1ps

module sine_wave_led_dimmer_top_tb;

   localparam int          LED_LIMIT   = 64;
   localparam int          TABLE_BITS  = 8;
   localparam int          TABLE_SIZE  = 1 << TABLE_BITS;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int          TAIL_CYCLES = 40;
   localparam int          RUN_LIMIT   = 400000;
   localparam int          PHASE_ITEMS = 46;
   localparam int          MAX_REPORTS = 10;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   swd_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   swd_pkg::rsp_type               rsp_data;
   logic                           csr_we = 1'b0;
   logic                           csr_index = swd_pkg::REG_FIRST_INDEX;
   logic [swd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // register mirror and tick counter of the predictor
   logic [9:0]  seg_first = 10'd0;
   logic [6:0]  seg_count = 7'd64;
   logic [31:0] tick_count = 32'd0;
   logic [7:0]  sine_quarter [0:TABLE_SIZE];

   swd_pkg::req_type pending_items [$];
   swd_pkg::rsp_type due_pixels [$];
   int      items_pushed = 0;
   int      items_accepted = 0;
   int      err_count = 0;
   int      cycle_count = 0;
   int      gap_pct = 0;
   int      stall_pct = 0;

   sine_wave_led_dimmer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // quarter-wave magnitude by truncated taylor series in q30
   function automatic logic [7:0] quarter_level(int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      x = (HALF_PI_Q30 * 64'(k)) / 64'(TABLE_SIZE);
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int j = 1; j <= 8; j++) begin
         term = ((term * x2) >> 30) / 64'((2 * j) * (2 * j + 1));
         if (j % 2 == 1) begin
            acc = (acc >= term) ? acc - term : 64'd0;
         end else begin
            acc = acc + term;
         end
      end
      acc = (64'd255 * acc + (64'd1 << 29)) >> 30;
      return (acc > 64'd255) ? 8'd255 : acc[7:0];
   endfunction

   // pixels of one tick, or a counter restart
   function automatic void predict_pixels(swd_pkg::req_type item);
      int unsigned      count;
      int unsigned      wl;
      int unsigned      angle;
      int unsigned      k;
      logic [15:0]      phase;
      logic [63:0]      phase_full;
      int               mag;
      int               level;
      swd_pkg::rsp_type pix;
      if (item.op == swd_pkg::OP_RESTART) begin
         tick_count = 32'd0;
         return;
      end
      count = (seg_count > LED_LIMIT) ? LED_LIMIT : seg_count;
      wl = (item.wavelength == 0) ? count : item.wavelength;
      phase_full = (64'(tick_count) * 64'(item.speed) * 64'd534) >> 8;
      phase = phase_full[15:0];
      for (int unsigned i = 0; i < count && wl != 0; i++) begin
         angle = ((i * 65536) / wl + phase) & 32'hFFFF;
         k = (angle & 32'h3FFF) >> (14 - TABLE_BITS);
         mag = (angle[14]) ? sine_quarter[TABLE_SIZE - k] : sine_quarter[k];
         if (angle[15]) begin
            mag = -mag;
         end
         level = (item.lightness * (255 + mag)) / 510;
         pix.pixel_index    = 11'(seg_first + i);
         pix.out_hue        = item.hue;
         pix.out_saturation = item.saturation;
         pix.out_lightness  = 8'(level);
         pix.last           = (i + 1 == count);
         due_pixels.push_back(pix);
      end
      tick_count = tick_count + 32'd1;
   endfunction

   function automatic swd_pkg::req_type make_item(logic op, int wl, int sp, int h, int s,
                                                  int l);
      swd_pkg::req_type item;
      item.op         = op;
      item.wavelength = 10'(wl);
      item.speed      = 10'(sp);
      item.hue        = 8'(h);
      item.saturation = 8'(s);
      item.lightness  = 8'(l);
      return item;
   endfunction

   function automatic swd_pkg::req_type random_item();
      swd_pkg::req_type item;
      int               pick;
      item = make_item(swd_pkg::OP_TICK, $urandom_range(1023), $urandom_range(1023),
                       $urandom_range(255), $urandom_range(255), $urandom_range(255));
      if ($urandom_range(99) < 8) begin
         item.op = swd_pkg::OP_RESTART;
      end
      pick = $urandom_range(9);
      if (pick < 2) begin
         item.wavelength = 10'd0;
      end else if (pick < 4) begin
         item.wavelength = 10'($urandom_range(8, 1));
      end else if (pick == 4) begin
         item.wavelength = 10'd1023;
      end
      pick = $urandom_range(9);
      if (pick == 0) begin
         item.speed = 10'd0;
      end else if (pick == 1) begin
         item.speed = 10'd1023;
      end
      if ($urandom_range(7) == 0) begin
         item.lightness = 8'd255;
      end
      return item;
   endfunction

   task automatic queue_item(swd_pkg::req_type item);
      pending_items.push_back(item);
      items_pushed++;
   endtask

   // register write, only issued while the block is idle
   task automatic write_reg(logic idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= swd_pkg::CSR_DATA_W'(value);
      if (idx == swd_pkg::REG_FIRST_INDEX) begin
         seg_first = 10'(value);
      end else begin
         seg_count = 7'(value);
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // all transfers taken, all pixels seen, then let the pipeline settle
   task automatic wait_idle();
      while (items_accepted != items_pushed || due_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : item_driver
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_pixels(req_data);
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // pixel monitor and checker
   always @(posedge clock) begin : pixel_check
      swd_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_pixels.size() == 0) begin
               err_count++;
               if (err_count <= MAX_REPORTS) begin
                  $display("unexpected pixel transfer: %p", rsp_data);
               end
            end else begin
               want = due_pixels.pop_front();
               if (rsp_data.pixel_index !== want.pixel_index ||
                   rsp_data.out_hue !== want.out_hue ||
                   rsp_data.out_saturation !== want.out_saturation ||
                   rsp_data.out_lightness !== want.out_lightness ||
                   rsp_data.last !== want.last) begin
                  err_count++;
                  if (err_count <= MAX_REPORTS) begin
                     $display("pixel mismatch: expected %p, got %p", want, rsp_data);
                  end
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
   end

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int gap_by_mode [4];
      int stall_by_mode [4];
      int first_sel [8];
      int count_sel [8];
      gap_by_mode   = '{0, 52, 0, 17};
      stall_by_mode = '{0, 0, 52, 17};
      for (int k = 0; k <= TABLE_SIZE; k++) begin
         sine_quarter[k] = quarter_level(k);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, field extremes, wrapping angle
      queue_item(make_item(swd_pkg::OP_RESTART, 0, 0, 0, 0, 0));
      queue_item(make_item(swd_pkg::OP_TICK, 0, 0, 0, 0, 0));
      queue_item(make_item(swd_pkg::OP_TICK, 0, 1023, 255, 255, 255));
      queue_item(make_item(swd_pkg::OP_TICK, 1, 1023, 18, 200, 255));
      queue_item(make_item(swd_pkg::OP_TICK, 1023, 512, 8'hAA, 8'h55, 200));
      queue_item(make_item(swd_pkg::OP_TICK, 2, 1, 1, 2, 128));
      queue_item(make_item(swd_pkg::OP_TICK, 64, 100, 77, 33, 255));
      queue_item(make_item(swd_pkg::OP_RESTART, 1023, 1023, 255, 255, 255));
      queue_item(make_item(swd_pkg::OP_TICK, 7, 300, 9, 240, 255));
      wait_idle();

      // oversized segment at the top of the strip
      write_reg(swd_pkg::REG_FIRST_INDEX, 1023);
      write_reg(swd_pkg::REG_LED_COUNT, 10'h3FF);
      queue_item(make_item(swd_pkg::OP_TICK, 0, 777, 100, 150, 255));
      queue_item(make_item(swd_pkg::OP_TICK, 1, 0, 3, 4, 1));
      wait_idle();

      // empty segment still advances the counter
      write_reg(swd_pkg::REG_FIRST_INDEX, 5);
      write_reg(swd_pkg::REG_LED_COUNT, 0);
      queue_item(make_item(swd_pkg::OP_TICK, 0, 200, 1, 1, 1));
      queue_item(make_item(swd_pkg::OP_TICK, 10, 1023, 2, 2, 2));
      queue_item(make_item(swd_pkg::OP_RESTART, 0, 0, 0, 0, 0));
      wait_idle();

      // single led, then one above the limit
      write_reg(swd_pkg::REG_LED_COUNT, 1);
      queue_item(make_item(swd_pkg::OP_TICK, 0, 5, 60, 70, 80));
      queue_item(make_item(swd_pkg::OP_TICK, 1023, 1023, 255, 0, 255));
      wait_idle();
      write_reg(swd_pkg::REG_FIRST_INDEX, 0);
      write_reg(swd_pkg::REG_LED_COUNT, 65);
      queue_item(make_item(swd_pkg::OP_TICK, 0, 1023, 128, 128, 255));
      queue_item(make_item(swd_pkg::OP_TICK, 0, 1023, 128, 128, 255));
      wait_idle();

      // random phases over the idling modes and segment settings
      first_sel = '{0, 1023, $urandom_range(1023), $urandom_range(1023),
                    1023, 0, $urandom_range(1023), $urandom_range(1023)};
      count_sel = '{64, 127, 1, 0, 64, $urandom_range(63, 2),
                    $urandom_range(127, 65), $urandom_range(127)};
      for (int p = 0; p < 8; p++) begin
         write_reg(swd_pkg::REG_FIRST_INDEX, first_sel[p]);
         write_reg(swd_pkg::REG_LED_COUNT, ($urandom_range(7) << 7) | count_sel[p]);
         gap_pct   = gap_by_mode[p % 4];
         stall_pct = stall_by_mode[p % 4];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            queue_item(random_item());
         end
         wait_idle();
      end

      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/swd_pkg.sv
hw/rtl/swd_div.sv
hw/rtl/swd_sine_rom.sv
hw/rtl/swd_shade.sv
hw/rtl/sine_wave_led_dimmer_top.sv
hw/rtl/swd_checker.sv
test/sine_wave_led_dimmer_top_tb.sv
